### sv/slcd_pkg.sv
// Package for the segment LCD memory writer: sizes, codes, payload types and the glyph font.
package slcd_pkg;

  localparam int MEMORY_BYTES   = 32;
  localparam int CHAR_POSITIONS = 6;
  localparam int ICON_SLOTS     = 8;

  localparam int ADDR_W = $clog2(MEMORY_BYTES);

  // Command opcodes
  localparam logic [2:0] OP_PUT_CHAR    = 3'd0;
  localparam logic [2:0] OP_ICON_ON     = 3'd1;
  localparam logic [2:0] OP_ICON_OFF    = 3'd2;
  localparam logic [2:0] OP_ICON_TOGGLE = 3'd3;
  localparam logic [2:0] OP_CLEAR_ALL   = 3'd4;
  localparam logic [2:0] OP_READ_BYTE   = 3'd5;

  // Configuration register indexes
  localparam logic [2:0] CFG_POS_FIRST  = 3'd0;
  localparam logic [2:0] CFG_POS_SECOND = 3'd1;
  localparam logic [2:0] CFG_SHARED     = 3'd2;
  localparam logic [2:0] CFG_ICON_LOW   = 3'd3;
  localparam logic [2:0] CFG_ICON_HIGH  = 3'd4;
  localparam logic [2:0] CFG_ICONS_USED = 3'd5;

  localparam int CFG_DATA_W = 52;

  typedef struct packed {
    logic [2:0] opcode;
    logic [2:0] position;
    logic [7:0] character;
    logic [3:0] icon_number;
    logic [4:0] read_index;
  } cmd_t;

  typedef struct packed {
    logic       status;
    logic [1:0] bytes_written;
    logic [4:0] first_index;
    logic [7:0] first_value;
    logic [4:0] second_index;
    logic [7:0] second_value;
    logic [7:0] read_value;
  } result_t;

  // Font entries: {byte 0, byte 1}
  localparam logic [15:0] DIGIT_GLYPHS [10] = '{
    16'hFC28, 16'h6020, 16'hDB00, 16'hF300, 16'h6700,
    16'hB700, 16'hBF00, 16'hE400, 16'hFF00, 16'hF700
  };

  localparam logic [15:0] LETTER_GLYPHS [26] = '{
    16'hEF00, 16'hF150, 16'h9C00, 16'hF050, 16'h9F00,
    16'h8F00, 16'hBD00, 16'h6F00, 16'h9050, 16'h7800,
    16'h0E22, 16'h1C00, 16'h6CA0, 16'h6C82, 16'hFC00,
    16'hCF00, 16'hFC02, 16'hCF02, 16'hB700, 16'h8050,
    16'h7C00, 16'h0C28, 16'h6C0A, 16'h00AA, 16'h00B0,
    16'h9028
  };

  localparam logic [15:0] DASH_GLYPH = 16'h0300;

  // Folds lower case, then looks up digits, letters and dash; anything else is blank.
  function automatic logic [15:0] glyph_of(logic [7:0] ch);
    logic [7:0]  c;
    logic [7:0]  d;
    logic [15:0] g;
    c = ch;
    if (c >= "a" && c <= "z") c = c - 8'h20;
    g = '0;
    d = '0;
    if (c >= "0" && c <= "9") begin
      d = c - "0";
      g = DIGIT_GLYPHS[d[3:0]];
    end else if (c >= "A" && c <= "Z") begin
      d = c - "A";
      g = LETTER_GLYPHS[d[4:0]];
    end else if (c == "-") begin
      g = DASH_GLYPH;
    end
    return g;
  endfunction

  // 5-bit memory index of a position from a packed position map
  function automatic logic [4:0] pos_index(logic [29:0] map, logic [2:0] pos);
    logic [4:0] r;
    r = '0;
    for (int k = 0; k < CHAR_POSITIONS; k++) begin
      if (pos == 3'(k)) r = map[5*k +: 5];
    end
    return r;
  endfunction

  // 13-bit icon slot {mask, index} out of a four-slot map
  function automatic logic [12:0] icon_slot(logic [51:0] map, logic [1:0] sel);
    logic [12:0] r;
    r = '0;
    for (int k = 0; k < 4; k++) begin
      if (sel == 2'(k)) r = map[13*k +: 13];
    end
    return r;
  endfunction

  // True when an index names a byte that exists in the segment memory
  function automatic logic in_memory(logic [4:0] idx);
    return {1'b0, idx} < 6'(MEMORY_BYTES);
  endfunction

endpackage

### sv/slcd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module slcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/segment_lcd_memory_writer_core.sv
// Top level of the segment LCD memory writer: command sequencer around the segment RAM.
//
//   channel   direction  handshake                       payload
//   command   in         start & !busy                   cmd_i    (slcd_pkg::cmd_t)
//   result    out        result_valid_o, one cycle       result_o (slcd_pkg::result_t)
//   config    in         cfg_valid_i & cfg_ready_o       cfg_index_i, cfg_data_i
//
// Every command passes through IDLE (accept), ACCESS (address the segment RAM:
// read port, plus the first glyph byte on the write port) and MERGE (merge the
// read data and write back), in that order; the registered RAM read data sets
// this. The result strobe shows in the cycle after the merge; start may be taken
// in that same cycle. Reset clears the state machine, the config registers and
// the per-byte valid bits (a byte without its valid bit reads as blank), so no
// clearing pass is needed. The result side cannot stall; config is always ready.
module segment_lcd_memory_writer_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  slcd_pkg::cmd_t                      cmd_i,
  output logic                                result_valid_o,
  output slcd_pkg::result_t                   result_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [2:0]                          cfg_index_i,
  input  logic [slcd_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_MERGE
  } state_e;

  state_e state_q;

  // Configuration registers
  logic [29:0] pos_first_q;
  logic [29:0] pos_second_q;
  logic [7:0]  shared_mask_q;
  logic [51:0] icon_low_q;
  logic [51:0] icon_high_q;
  logic [3:0]  icons_used_q;

  // Latched command
  slcd_pkg::cmd_t cmd_q;

  // Valid bit per segment byte; clear all just drops these
  logic [slcd_pkg::MEMORY_BYTES-1:0] valid_q;

  slcd_pkg::result_t result_q;
  slcd_pkg::result_t result_d;
  logic              result_valid_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_first_q   <= '0;
      pos_second_q  <= '0;
      shared_mask_q <= '0;
      icon_low_q    <= '0;
      icon_high_q   <= '0;
      icons_used_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        slcd_pkg::CFG_POS_FIRST:  pos_first_q   <= cfg_data_i[29:0];
        slcd_pkg::CFG_POS_SECOND: pos_second_q  <= cfg_data_i[29:0];
        slcd_pkg::CFG_SHARED:     shared_mask_q <= cfg_data_i[7:0];
        slcd_pkg::CFG_ICON_LOW:   icon_low_q    <= cfg_data_i;
        slcd_pkg::CFG_ICON_HIGH:  icon_high_q   <= cfg_data_i;
        slcd_pkg::CFG_ICONS_USED: icons_used_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // ---- Decode of the latched command (stable through ACCESS and MERGE) ----
  logic        is_put, is_icon, is_clear, is_read;
  logic        pos_bad, icon_bad;
  logic [3:0]  icon_limit;
  logic [4:0]  idx0, idx1;
  logic [15:0] glyph;
  logic [7:0]  g0, g1;
  logic [12:0] slot;
  logic [4:0]  icon_idx;
  logic [7:0]  icon_mask;
  logic [4:0]  rd_idx;

  always_comb begin
    is_put   = (cmd_q.opcode == slcd_pkg::OP_PUT_CHAR);
    is_icon  = (cmd_q.opcode == slcd_pkg::OP_ICON_ON) ||
               (cmd_q.opcode == slcd_pkg::OP_ICON_OFF) ||
               (cmd_q.opcode == slcd_pkg::OP_ICON_TOGGLE);
    is_clear = (cmd_q.opcode == slcd_pkg::OP_CLEAR_ALL);
    is_read  = (cmd_q.opcode == slcd_pkg::OP_READ_BYTE);

    pos_bad    = cmd_q.position >= 3'(slcd_pkg::CHAR_POSITIONS);
    // icons_used above the slot count saturates
    icon_limit = (icons_used_q > 4'(slcd_pkg::ICON_SLOTS)) ?
                 4'(slcd_pkg::ICON_SLOTS) : icons_used_q;
    icon_bad   = cmd_q.icon_number >= icon_limit;

    idx0  = slcd_pkg::pos_index(pos_first_q, cmd_q.position);
    idx1  = slcd_pkg::pos_index(pos_second_q, cmd_q.position);
    glyph = slcd_pkg::glyph_of(cmd_q.character);
    g0    = glyph[15:8];
    g1    = glyph[7:0];

    slot      = slcd_pkg::icon_slot(cmd_q.icon_number[2] ? icon_high_q : icon_low_q,
                                    cmd_q.icon_number[1:0]);
    icon_idx  = slot[4:0];
    icon_mask = slot[12:5];

    // Byte that the merge step needs
    priority if (is_put)  rd_idx = idx1;
    else if (is_icon)     rd_idx = icon_idx;
    else                  rd_idx = cmd_q.read_index;
  end

  // ---- RAM control ----
  logic                        ram_we, ram_re;
  logic [slcd_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]                  ram_wdata, ram_rdata;
  logic [4:0]                  wr_idx;
  logic [7:0]                  old_val, new_val, merged;
  logic                        op_ok;

  always_comb begin
    op_ok = (is_put && !pos_bad) || (is_icon && !icon_bad);

    // Old byte: beyond memory reads blank; the glyph byte written in ACCESS
    // to the same index is forwarded; a never-written byte is blank.
    if (!slcd_pkg::in_memory(rd_idx))       old_val = '0;
    else if (is_put && (idx0 == idx1))      old_val = g0;
    else if (valid_q[rd_idx[slcd_pkg::ADDR_W-1:0]]) old_val = ram_rdata;
    else                                    old_val = '0;

    merged = (g1 & ~shared_mask_q) | (old_val & shared_mask_q);

    unique case (cmd_q.opcode)
      slcd_pkg::OP_ICON_ON:  new_val = old_val | icon_mask;
      slcd_pkg::OP_ICON_OFF: new_val = old_val & ~icon_mask;
      default:               new_val = old_val ^ icon_mask;
    endcase

    ram_re    = (state_q == ST_ACCESS);
    ram_raddr = rd_idx[slcd_pkg::ADDR_W-1:0];

    ram_we    = 1'b0;
    wr_idx    = idx0;
    ram_wdata = g0;
    if (state_q == ST_ACCESS) begin
      // first glyph byte goes out while the second byte is read
      wr_idx    = idx0;
      ram_wdata = g0;
      ram_we    = is_put && !pos_bad && slcd_pkg::in_memory(idx0);
    end else if (state_q == ST_MERGE) begin
      wr_idx    = is_put ? idx1 : icon_idx;
      ram_wdata = is_put ? merged : new_val;
      ram_we    = op_ok && slcd_pkg::in_memory(wr_idx);
    end
    ram_waddr = wr_idx[slcd_pkg::ADDR_W-1:0];
  end

  slcd_ram #(
    .WIDTH (8),
    .DEPTH (slcd_pkg::MEMORY_BYTES)
  ) u_seg_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (state_q == ST_ACCESS && is_clear) begin
      valid_q <= '0;
    end else if (ram_we) begin
      valid_q[ram_waddr] <= 1'b1;
    end
  end

  // Result of the command in MERGE; unused fields stay zero
  always_comb begin
    result_d = '0;
    if (is_put) begin
      if (pos_bad) begin
        result_d.status = 1'b1;
      end else begin
        result_d.bytes_written = 2'd2;
        result_d.first_index   = idx0;
        result_d.first_value   = g0;
        result_d.second_index  = idx1;
        result_d.second_value  = merged;
      end
    end else if (is_icon) begin
      if (icon_bad) begin
        result_d.status = 1'b1;
      end else begin
        result_d.bytes_written = 2'd1;
        result_d.first_index   = icon_idx;
        result_d.first_value   = new_val;
      end
    end else if (is_read) begin
      result_d.read_value = old_val;
    end
  end

  // ---- Sequencer and result register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      result_valid_q <= 1'b0;
      cmd_q          <= '0;
      result_q       <= '0;
    end else begin
      result_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            cmd_q   <= cmd_i;
            state_q <= ST_ACCESS;
          end
        end
        ST_ACCESS: begin
          state_q <= ST_MERGE;
        end
        ST_MERGE: begin
          result_q       <= result_d;
          result_valid_q <= 1'b1;
          state_q        <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

endmodule

### tb/sv/segment_lcd_memory_writer_core_tb.sv
// Self-checking testbench for the segment LCD memory writer core.
module segment_lcd_memory_writer_core_tb;
  import slcd_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned MAX_GAP       = 17;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RAND_PHASES   = 12;
  localparam int unsigned PHASE_CMDS    = 121;

  // Opcodes the block must ignore
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  // Font, {byte 0, byte 1}
  localparam logic [15:0] FONT_DIGITS [10] = '{
    16'hFC28, 16'h6020, 16'hDB00, 16'hF300, 16'h6700,
    16'hB700, 16'hBF00, 16'hE400, 16'hFF00, 16'hF700
  };
  localparam logic [15:0] FONT_LETTERS [26] = '{
    16'hEF00, 16'hF150, 16'h9C00, 16'hF050, 16'h9F00,
    16'h8F00, 16'hBD00, 16'h6F00, 16'h9050, 16'h7800,
    16'h0E22, 16'h1C00, 16'h6CA0, 16'h6C82, 16'hFC00,
    16'hCF00, 16'hFC02, 16'hCF02, 16'hB700, 16'h8050,
    16'h7C00, 16'h0C28, 16'h6C0A, 16'h00AA, 16'h00B0,
    16'h9028
  };
  localparam logic [15:0] FONT_DASH = 16'h0300;

  typedef enum logic [1:0] {STEP_CMD, STEP_CFG, STEP_DRAIN} step_kind_e;

  typedef struct {
    step_kind_e            kind;
    cmd_t                  cmd;
    logic [2:0]            reg_idx;
    logic [CFG_DATA_W-1:0] data;
    int unsigned           gap;
  } lcd_step_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  start       = 1'b0;
  logic                  busy;
  cmd_t                  cmd_i       = '0;
  logic                  result_valid_o;
  result_t               result_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [2:0]            cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  // Shadow copy of the segment memory and the register file
  logic [7:0]  seg_shadow [MEMORY_BYTES];
  logic [29:0] map_first  = '0;
  logic [29:0] map_second = '0;
  logic [7:0]  keep_mask  = '0;
  logic [51:0] icons_lo   = '0;
  logic [51:0] icons_hi   = '0;
  logic [3:0]  icons_used = '0;

  lcd_step_t   plan_q [$];
  result_t     expected_q [$];

  int unsigned issued    = 0;
  int unsigned received  = 0;
  int unsigned err_cnt   = 0;
  int unsigned cycle_cnt = 0;
  int unsigned n_put = 0, n_icon = 0, n_read = 0, n_clear = 0, n_spare = 0;
  int unsigned n_flagged = 0, n_cfg = 0;

  bit          idle_on   = 1'b1;
  bit          gap_armed = 1'b0;
  int unsigned gap_left  = 0;
  logic        took_cmd, took_cfg, next_start, next_cfg;
  lcd_step_t   front;
  result_t     want;

  segment_lcd_memory_writer_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  function automatic logic [7:0] seg_fetch(logic [4:0] idx);
    if (idx < MEMORY_BYTES) return seg_shadow[idx];
    return 8'h00;
  endfunction

  function automatic void seg_store(logic [4:0] idx, logic [7:0] val);
    if (idx < MEMORY_BYTES) seg_shadow[idx] = val;
  endfunction

  // Applies one command to the shadow state and returns the result it should give
  function automatic result_t predict_result(cmd_t c);
    result_t     r;
    logic [4:0]  i0, i1;
    logic [7:0]  up, merged, bits, v;
    logic [12:0] slot;
    logic [15:0] glyph;
    int unsigned limit;
    r = '0;
    case (c.opcode)
      OP_PUT_CHAR: begin
        n_put++;
        if (c.position >= CHAR_POSITIONS) begin
          r.status = 1'b1;
        end else begin
          i0 = map_first[5*c.position +: 5];
          i1 = map_second[5*c.position +: 5];
          up = c.character;
          if (up >= "a" && up <= "z") up = up - 8'h20;
          if (up >= "0" && up <= "9") glyph = FONT_DIGITS[up - "0"];
          else if (up >= "A" && up <= "Z") glyph = FONT_LETTERS[up - "A"];
          else if (up == "-") glyph = FONT_DASH;
          else glyph = '0;
          // byte 0 lands first, so a shared index merges against the new value
          seg_store(i0, glyph[15:8]);
          merged = (glyph[7:0] & ~keep_mask) | (seg_fetch(i1) & keep_mask);
          seg_store(i1, merged);
          r.bytes_written = 2'd2;
          r.first_index   = i0;
          r.first_value   = glyph[15:8];
          r.second_index  = i1;
          r.second_value  = merged;
        end
      end
      OP_ICON_ON, OP_ICON_OFF, OP_ICON_TOGGLE: begin
        n_icon++;
        limit = (icons_used > ICON_SLOTS) ? ICON_SLOTS : icons_used;
        if (c.icon_number >= limit) begin
          r.status = 1'b1;
        end else begin
          slot = c.icon_number[2] ? icons_hi[13*c.icon_number[1:0] +: 13]
                                  : icons_lo[13*c.icon_number[1:0] +: 13];
          bits = slot[12:5];
          v    = seg_fetch(slot[4:0]);
          case (c.opcode)
            OP_ICON_ON:  v = v | bits;
            OP_ICON_OFF: v = v & ~bits;
            default:     v = v ^ bits;
          endcase
          seg_store(slot[4:0], v);
          r.bytes_written = 2'd1;
          r.first_index   = slot[4:0];
          r.first_value   = v;
        end
      end
      OP_CLEAR_ALL: begin
        n_clear++;
        foreach (seg_shadow[k]) seg_shadow[k] = 8'h00;
      end
      OP_READ_BYTE: begin
        n_read++;
        r.read_value = seg_fetch(c.read_index);
      end
      default: n_spare++;
    endcase
    if (r.status) n_flagged++;
    return r;
  endfunction

  function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
    if (exp_v !== got_v) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
    end
  endfunction

  function automatic cmd_t mk_cmd(logic [2:0] op, logic [2:0] pos, logic [7:0] ch,
                                  logic [3:0] icon, logic [4:0] ridx);
    cmd_t c;
    c.opcode      = op;
    c.position    = pos;
    c.character   = ch;
    c.icon_number = icon;
    c.read_index  = ridx;
    return c;
  endfunction

  // Pre-item wait; at least a quarter of the items go back to back even when idling is on
  function automatic int unsigned draw_gap();
    if (!idle_on || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  function automatic void push_cmd(cmd_t c);
    lcd_step_t s;
    s.kind    = STEP_CMD;
    s.cmd     = c;
    s.reg_idx = '0;
    s.data    = '0;
    s.gap     = draw_gap();
    plan_q.push_back(s);
  endfunction

  function automatic void push_cfg(logic [2:0] idx, logic [CFG_DATA_W-1:0] d);
    lcd_step_t s;
    s.kind    = STEP_CFG;
    s.cmd     = '0;
    s.reg_idx = idx;
    s.data    = d;
    s.gap     = draw_gap();
    plan_q.push_back(s);
  endfunction

  function automatic void push_drain();
    lcd_step_t s;
    s.kind    = STEP_DRAIN;
    s.cmd     = '0;
    s.reg_idx = '0;
    s.data    = '0;
    s.gap     = draw_gap();
    plan_q.push_back(s);
  endfunction

  // Driver. Commands go out as soon as their gap is spent; register writes and
  // drain steps also wait until every issued command has returned its result.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start       <= 1'b0;
      cmd_i       <= '0;
      cfg_valid_i <= 1'b0;
      cfg_index_i <= '0;
      cfg_data_i  <= '0;
      issued      <= 0;
      gap_armed   = 1'b0;
      gap_left    = 0;
      foreach (seg_shadow[k]) seg_shadow[k] = 8'h00;
      map_first  = '0;
      map_second = '0;
      keep_mask  = '0;
      icons_lo   = '0;
      icons_hi   = '0;
      icons_used = '0;
    end else begin
      took_cmd = start && !busy;
      took_cfg = cfg_valid_i && cfg_ready_o;
      if (took_cmd) begin
        expected_q.push_back(predict_result(cmd_i));
        issued <= issued + 1;
      end
      if (took_cfg) begin
        n_cfg++;
        case (cfg_index_i)
          CFG_POS_FIRST:  map_first  = cfg_data_i[29:0];
          CFG_POS_SECOND: map_second = cfg_data_i[29:0];
          CFG_SHARED:     keep_mask  = cfg_data_i[7:0];
          CFG_ICON_LOW:   icons_lo   = cfg_data_i[51:0];
          CFG_ICON_HIGH:  icons_hi   = cfg_data_i[51:0];
          CFG_ICONS_USED: icons_used = cfg_data_i[3:0];
          default: ;
        endcase
      end
      next_start = start && !took_cmd;
      next_cfg   = cfg_valid_i && !took_cfg;
      if (!next_start && !next_cfg && plan_q.size() != 0) begin
        if (!gap_armed) begin
          gap_left  = plan_q[0].gap;
          gap_armed = 1'b1;
        end
        if (gap_left != 0) begin
          gap_left--;
        end else if (plan_q[0].kind == STEP_CMD) begin
          front      = plan_q.pop_front();
          cmd_i      <= front.cmd;
          next_start = 1'b1;
          gap_armed  = 1'b0;
        end else if (!took_cmd && !busy && issued == received) begin
          front     = plan_q.pop_front();
          gap_armed = 1'b0;
          if (front.kind == STEP_CFG) begin
            cfg_index_i <= front.reg_idx;
            cfg_data_i  <= front.data;
            next_cfg    = 1'b1;
          end
        end
      end
      start       <= next_start;
      cfg_valid_i <= next_cfg;
    end
  end

  // Monitor: every strobe is one result transfer, checked against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      received <= 0;
    end else if (result_valid_o) begin
      received <= received + 1;
      if (expected_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result, expected none, actual %h", $time, result_o);
      end else begin
        want = expected_q.pop_front();
        check_field("status",        want.status,        result_o.status);
        check_field("bytes_written", want.bytes_written, result_o.bytes_written);
        check_field("first_index",   want.first_index,   result_o.first_index);
        check_field("first_value",   want.first_value,   result_o.first_value);
        check_field("second_index",  want.second_index,  result_o.second_index);
        check_field("second_value",  want.second_value,  result_o.second_value);
        check_field("read_value",    want.read_value,    result_o.read_value);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still outstanding", $time, expected_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    cmd_t        c;
    logic [63:0] w0, w1, w2, w3, w4, w5;
    int unsigned r;

    // Registers at reset: every position and byte sit at index zero, no icons
    push_cmd(mk_cmd(OP_PUT_CHAR, 3'd0, "A", 4'd0, 5'd0));
    push_cmd(mk_cmd(OP_READ_BYTE, 3'd0, 8'h00, 4'd0, 5'd0));
    push_cmd(mk_cmd(OP_ICON_ON, 3'd0, 8'h00, 4'd0, 5'd0));
    push_cmd(mk_cmd(OP_PUT_CHAR, 3'd6, "B", 4'd0, 5'd0));
    push_cmd(mk_cmd(OP_PUT_CHAR, 3'd7, "C", 4'd0, 5'd0));
    push_cmd(mk_cmd(OP_SPARE_A, 3'd7, 8'hFF, 4'hF, 5'h1F));
    push_cmd(mk_cmd(OP_SPARE_B, 3'd0, 8'h00, 4'h0, 5'h00));

    // Known layout: icon 0 shares the second byte of position 0
    push_cfg(CFG_POS_FIRST,  52'({5'd5, 5'd4, 5'd3, 5'd2, 5'd1, 5'd0}));
    push_cfg(CFG_POS_SECOND, 52'({5'd13, 5'd12, 5'd11, 5'd10, 5'd9, 5'd8}));
    push_cfg(CFG_SHARED,     52'h0C0);
    push_cfg(CFG_ICON_LOW,   {8'h01, 5'd31, 8'hFF, 5'd20, 8'h80, 5'd9, 8'hC0, 5'd8});
    push_cfg(CFG_ICON_HIGH,  {8'h55, 5'd27, 8'hAA, 5'd26, 8'hF0, 5'd25, 8'h0F, 5'd24});
    push_cfg(CFG_ICONS_USED, 52'd8);
    push_cmd(mk_cmd(OP_ICON_ON, 3'd0, 8'h00, 4'd0, 5'd0));
    push_cmd(mk_cmd(OP_PUT_CHAR, 3'd0, "0", 4'd0, 5'd0));
    push_cmd(mk_cmd(OP_PUT_CHAR, 3'd1, "9", 4'd0, 5'd0));
    push_cmd(mk_cmd(OP_PUT_CHAR, 3'd2, "a", 4'd0, 5'd0));
    push_cmd(mk_cmd(OP_PUT_CHAR, 3'd3, "z", 4'd0, 5'd0));
    push_cmd(mk_cmd(OP_PUT_CHAR, 3'd5, "-", 4'd0, 5'd0));
    push_cmd(mk_cmd(OP_PUT_CHAR, 3'd0, "@", 4'd0, 5'd0));
    push_cmd(mk_cmd(OP_PUT_CHAR, 3'd1, 8'hFF, 4'd0, 5'd0));
    push_cmd(mk_cmd(OP_ICON_OFF, 3'd0, 8'h00, 4'd1, 5'd0));
    push_cmd(mk_cmd(OP_ICON_TOGGLE, 3'd0, 8'h00, 4'd7, 5'd0));
    push_cmd(mk_cmd(OP_ICON_TOGGLE, 3'd0, 8'h00, 4'd2, 5'd0));
    push_cmd(mk_cmd(OP_ICON_ON, 3'd0, 8'h00, 4'd8, 5'd0));
    push_cmd(mk_cmd(OP_ICON_OFF, 3'd0, 8'h00, 4'd15, 5'd0));
    push_cmd(mk_cmd(OP_READ_BYTE, 3'd0, 8'h00, 4'd0, 5'd8));
    push_cmd(mk_cmd(OP_READ_BYTE, 3'd0, 8'h00, 4'd0, 5'd31));
    push_cmd(mk_cmd(OP_CLEAR_ALL, 3'd0, 8'h00, 4'd0, 5'd0));
    push_cmd(mk_cmd(OP_READ_BYTE, 3'd0, 8'h00, 4'd0, 5'd8));

    // Icon count above the slot count behaves as eight
    push_cfg(CFG_ICONS_USED, 52'd15);
    push_cmd(mk_cmd(OP_ICON_TOGGLE, 3'd0, 8'h00, 4'd7, 5'd0));
    push_cmd(mk_cmd(OP_ICON_ON, 3'd0, 8'h00, 4'd8, 5'd0));
    push_cfg(CFG_ICONS_USED, 52'd3);
    push_cmd(mk_cmd(OP_ICON_ON, 3'd0, 8'h00, 4'd2, 5'd0));
    push_cmd(mk_cmd(OP_ICON_ON, 3'd0, 8'h00, 4'd3, 5'd0));

    // Random phases: all ones, all zero, then random settings, one phase with shared byte maps
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      idle_on = (ph % 3 != 1);
      w0 = {$urandom, $urandom};
      w1 = (ph == 3) ? w0 : {$urandom, $urandom};
      w2 = {$urandom, $urandom};
      r  = $urandom_range(0, 3);
      if (r == 0) w2[7:0] = 8'h00;
      else if (r == 1) w2[7:0] = 8'hFF;
      w3 = {$urandom, $urandom};
      w4 = {$urandom, $urandom};
      w5 = {$urandom, $urandom};
      w5[3:0] = $urandom_range(0, 1) ? 4'd8 : 4'($urandom_range(0, 15));
      if (ph == 0) begin
        w0 = '1; w1 = '1; w2 = '1; w3 = '1; w4 = '1; w5 = '1;
      end else if (ph == 1) begin
        w0 = '0; w1 = '0; w2 = '0; w3 = '0; w4 = '0; w5 = '0;
      end
      push_cfg(CFG_POS_FIRST,  w0[51:0]);
      push_cfg(CFG_POS_SECOND, w1[51:0]);
      push_cfg(CFG_SHARED,     w2[51:0]);
      push_cfg(CFG_ICON_LOW,   w3[51:0]);
      push_cfg(CFG_ICON_HIGH,  w4[51:0]);
      push_cfg(CFG_ICONS_USED, w5[51:0]);

      for (int n = 0; n < PHASE_CMDS; n++) begin
        // unused fields keep random bits
        c = 23'($urandom);
        r = $urandom_range(0, 99);
        if (r < 34) c.opcode = OP_PUT_CHAR;
        else if (r < 64) c.opcode = 3'($urandom_range(OP_ICON_ON, OP_ICON_TOGGLE));
        else if (r < 67) c.opcode = OP_CLEAR_ALL;
        else if (r < 94) c.opcode = OP_READ_BYTE;
        else c.opcode = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
        c.position = ($urandom_range(0, 6) == 0) ? 3'($urandom_range(6, 7))
                                                 : 3'($urandom_range(0, 5));
        case ($urandom_range(0, 4))
          0: c.character = 8'("0" + $urandom_range(0, 9));
          1: c.character = 8'("A" + $urandom_range(0, 25));
          2: c.character = 8'("a" + $urandom_range(0, 25));
          3: c.character = $urandom_range(0, 7) == 0 ? "-" : 8'($urandom);
          default: c.character = 8'($urandom);
        endcase
        if ($urandom_range(0, 3) != 0) c.icon_number = 4'($urandom_range(0, 7));
        push_cmd(c);
        // hold the sender until the block has drained
        if (n % 40 == 39) push_drain();
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (plan_q.size() != 0 || start || cfg_valid_i || issued != received);
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    if (expected_q.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d results never arrived, expected %h first, actual none",
               $time, expected_q.size(), expected_q[0]);
    end
    $display("Covered %0d commands: %0d put char, %0d icon, %0d read, %0d clear, %0d spare.",
             issued, n_put, n_icon, n_read, n_clear, n_spare);
    $display("%0d rejected as out of range; %0d register writes across %0d settings.",
             n_flagged, n_cfg, RAND_PHASES + 4);
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### segment_lcd_memory_writer_core.f
sv/slcd_pkg.sv
sv/slcd_ram.sv
sv/segment_lcd_memory_writer_core.sv
tb/sv/segment_lcd_memory_writer_core_tb.sv
